// ----- hw/rtl/spr_pkg.sv -----
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants of the sensor poll recovery supervisor.
// ----------------------------------------------------------------------------
package spr_pkg;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 72;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  // Item kinds carried on the input side band.
  localparam logic KIND_POLL = 1'b0;
  localparam logic KIND_RESP = 1'b1;

  // Response outcome codes.
  localparam logic [1:0] OUTC_OK        = 2'd0;
  localparam logic [1:0] OUTC_NOT_READY = 2'd1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGR_RETRY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT   = 2'd2;

  localparam logic [15:0] POLL_INTERVAL_RST = 16'd100;
  localparam logic [31:0] DEGR_RETRY_RST    = 32'd5000;
  localparam logic [7:0]  ERROR_LIMIT_RST   = 8'd3;
  localparam logic [7:0]  ERR_COUNT_MAX     = 8'hFF;

  typedef enum logic [2:0] {
    MODE_INIT    = 3'd0,
    MODE_RUN     = 3'd1,
    MODE_RETRY   = 3'd2,
    MODE_BUSRST  = 3'd3,
    MODE_SOFTRST = 3'd4,
    MODE_DEGR    = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ACT_NONE = 3'd0,
    ACT_INIT = 3'd1,
    ACT_BUS  = 3'd2,
    ACT_SOFT = 3'd3,
    ACT_READ = 3'd4
  } act_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] now_ms;
    logic [1:0]  outcome;
    logic [7:0]  clear_low;
    logic [7:0]  clear_high;
    logic [7:0]  red_low;
    logic [7:0]  red_high;
    logic [7:0]  green_low;
    logic [7:0]  green_high;
    logic [7:0]  blue_low;
    logic [7:0]  blue_high;
  } in_item_t;

  typedef struct packed {
    act_t        action;
    mode_t       mode;
    logic        available;
    logic [15:0] clear_value;
    logic [15:0] red_value;
    logic [15:0] green_value;
    logic [15:0] blue_value;
  } out_item_t;

endpackage

// ----- hw/rtl/spr_in_stage.sv -----
// ----------------------------------------------------------------------------
// spr_in_stage
// Input register: captures one transfer and unpacks it into an item.
// ----------------------------------------------------------------------------
module spr_in_stage (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [spr_pkg::IN_TDATA_W-1:0] in_tdata,  // now_ms, outcome, clear lo/hi,
                                                    // red lo/hi, green lo/hi, blue lo/hi
  input  logic                         in_tuser,  // kind
  input  logic                         advance,
  output logic                         item_valid,
  output spr_pkg::in_item_t            item
);
  import spr_pkg::*;

  logic     valid_r, valid_nxt;
  in_item_t item_r;
  logic     accept;

  assign in_tready = !valid_r || advance;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.kind       <= in_tuser;
      item_r.now_ms     <= in_tdata[31:0];
      item_r.outcome    <= in_tdata[33:32];
      item_r.clear_low  <= in_tdata[41:34];
      item_r.clear_high <= in_tdata[49:42];
      item_r.red_low    <= in_tdata[57:50];
      item_r.red_high   <= in_tdata[65:58];
      item_r.green_low  <= in_tdata[73:66];
      item_r.green_high <= in_tdata[81:74];
      item_r.blue_low   <= in_tdata[89:82];
      item_r.blue_high  <= in_tdata[97:90];
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ----- hw/rtl/spr_core.sv -----
// ----------------------------------------------------------------------------
// spr_core
// Recovery state machine, configuration registers and stored colour reading.
// ----------------------------------------------------------------------------
module spr_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [spr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            step_en,
  input  spr_pkg::in_item_t               item,
  output spr_pkg::out_item_t              res
);
  import spr_pkg::*;

  logic [15:0] poll_interval_r;
  logic [31:0] degr_retry_r;
  logic [7:0]  error_limit_r;

  mode_t       mode_r, mode_nxt;
  act_t        pending_r, pending_nxt;
  logic        awaiting_r, awaiting_nxt;
  logic        valid_r, valid_nxt;
  logic [7:0]  err_r, err_nxt;
  logic [31:0] last_poll_r, last_poll_nxt;
  logic [31:0] degr_mark_r, degr_mark_nxt;
  logic [15:0] store_r   [4];
  logic [15:0] store_nxt [4];

  logic [31:0] poll_dt;
  logic [31:0] degr_dt;
  logic        poll_go;
  logic        degr_due;
  logic        resp_go;
  logic        resp_ok;
  logic [7:0]  err_inc;
  act_t        action;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_interval_r <= POLL_INTERVAL_RST;
      degr_retry_r    <= DEGR_RETRY_RST;
      error_limit_r   <= ERROR_LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_POLL_INTERVAL: poll_interval_r <= cfg_wdata[15:0];
        CFG_DEGR_RETRY:    degr_retry_r    <= cfg_wdata;
        CFG_ERROR_LIMIT:   error_limit_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Both time checks use modular differences, so a wrapped clock still works.
  assign poll_dt  = item.now_ms - last_poll_r;
  assign degr_dt  = item.now_ms - degr_mark_r;
  assign poll_go  = step_en && (item.kind == KIND_POLL) && !awaiting_r
                    && (poll_dt >= {16'd0, poll_interval_r});
  assign degr_due = degr_dt >= degr_retry_r;
  assign resp_go  = step_en && (item.kind == KIND_RESP) && awaiting_r;
  assign resp_ok  = item.outcome == OUTC_OK;
  assign err_inc  = (err_r == ERR_COUNT_MAX) ? err_r : err_r + 8'd1;

  // Action issued by an accepted poll.
  always_comb begin
    action = ACT_NONE;
    if (poll_go) begin
      unique case (mode_r)
        MODE_INIT:    action = ACT_INIT;
        MODE_RUN:     action = ACT_READ;
        MODE_RETRY:   action = ACT_INIT;
        MODE_BUSRST:  action = ACT_BUS;
        MODE_SOFTRST: action = ACT_SOFT;
        default:      action = ACT_NONE;
      endcase
    end
  end

  // Next state.
  always_comb begin
    mode_nxt      = mode_r;
    pending_nxt   = pending_r;
    awaiting_nxt  = awaiting_r;
    valid_nxt     = valid_r;
    err_nxt       = err_r;
    last_poll_nxt = last_poll_r;
    degr_mark_nxt = degr_mark_r;
    store_nxt     = store_r;
    if (poll_go) begin
      last_poll_nxt = item.now_ms;
      if (action != ACT_NONE) begin
        awaiting_nxt = 1'b1;
        pending_nxt  = action;
      end else begin
        // Degraded: the reading is dropped and recovery restarts after a while.
        valid_nxt = 1'b0;
        if (degr_due) begin
          degr_mark_nxt = item.now_ms;
          mode_nxt      = MODE_RETRY;
        end
      end
    end else if (resp_go) begin
      awaiting_nxt = 1'b0;
      pending_nxt  = ACT_NONE;
      if (pending_r == ACT_READ) begin
        if (resp_ok) begin
          store_nxt[0] = {item.clear_high, item.clear_low};
          store_nxt[1] = {item.red_high, item.red_low};
          store_nxt[2] = {item.green_high, item.green_low};
          store_nxt[3] = {item.blue_high, item.blue_low};
          valid_nxt    = 1'b1;
          err_nxt      = 8'd0;
        end else if (item.outcome != OUTC_NOT_READY) begin
          err_nxt   = err_inc;
          valid_nxt = 1'b0;
          if (err_inc >= error_limit_r) begin
            mode_nxt = MODE_RETRY;
          end
        end
      end else if (resp_ok) begin
        mode_nxt = MODE_RUN;
        err_nxt  = 8'd0;
      end else if (pending_r == ACT_INIT) begin
        mode_nxt = (mode_r == MODE_INIT) ? MODE_RETRY : MODE_BUSRST;
      end else if (pending_r == ACT_BUS) begin
        mode_nxt = MODE_SOFTRST;
      end else begin
        mode_nxt = MODE_DEGR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_INIT;
      pending_r   <= ACT_NONE;
      awaiting_r  <= 1'b0;
      valid_r     <= 1'b0;
      err_r       <= 8'd0;
      last_poll_r <= 32'd0;
      degr_mark_r <= 32'd0;
      store_r     <= '{default: 16'd0};
    end else begin
      mode_r      <= mode_nxt;
      pending_r   <= pending_nxt;
      awaiting_r  <= awaiting_nxt;
      valid_r     <= valid_nxt;
      err_r       <= err_nxt;
      last_poll_r <= last_poll_nxt;
      degr_mark_r <= degr_mark_nxt;
      store_r     <= store_nxt;
    end
  end

  // The result reports the state as it stands after this item.
  always_comb begin
    res.action      = action;
    res.mode        = mode_nxt;
    res.available   = valid_nxt;
    res.clear_value = store_nxt[0];
    res.red_value   = store_nxt[1];
    res.green_value = store_nxt[2];
    res.blue_value  = store_nxt[3];
  end

`ifndef SYNTHESIS
  a_pending_matches_wait: assert property (@(posedge clk) disable iff (!rst_n)
    awaiting_r == (pending_r != ACT_NONE))
    else $error("pending action disagrees with the wait flag");

  a_action_starts_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && action != ACT_NONE) |=> awaiting_r)
    else $error("issued action did not start a wait");

  a_degraded_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && mode_r == MODE_DEGR) |-> (action == ACT_NONE))
    else $error("action issued in degraded mode");

  a_valid_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(valid_r) |-> $past(resp_go && pending_r == ACT_READ && resp_ok))
    else $error("reading became available without a good read");
`endif

endmodule

// ----- hw/rtl/spr_out_stage.sv -----
// ----------------------------------------------------------------------------
// spr_out_stage
// Result register: holds one packed result until the sink takes it.
// ----------------------------------------------------------------------------
module spr_out_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            load,
  input  spr_pkg::out_item_t              res,
  output logic                            space,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [spr_pkg::OUT_TDATA_W-1:0] out_tdata  // action, mode, available, clear,
                                                     // red, green, blue values
);
  import spr_pkg::*;

  logic                   valid_r, valid_nxt;
  logic [OUT_TDATA_W-1:0] data_r;

  assign space = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= {1'b0, res.blue_value, res.green_value, res.red_value, res.clear_value,
                 res.available, res.mode, res.action};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

// ----- hw/rtl/sensor_poll_recovery_fsm.sv -----
// ----------------------------------------------------------------------------
// sensor_poll_recovery_fsm
// Poll-driven supervisor of a colour sensor with escalating fault recovery.
//
//   Channel  Direction  Ports                               Contents
//   in       sink       in_tvalid/tready/tdata/tuser        poll or response
//   out      source     out_tvalid/tready/tdata             action, mode, reading
//   cfg      sink       cfg_wr_en/index/wdata               three control registers
//
// One item per cycle sustained while the sink takes results; each result passes
// the input register and then the result register before it is presented.
// The whole state update is combinational between those two registers.
// Reset is synchronous, active low, and loads the register defaults.
// A stalled sink holds the result register; the input register then fills
// and in_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module sensor_poll_recovery_fsm (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [spr_pkg::IN_TDATA_W-1:0]   in_tdata,  // now_ms, outcome, clear lo/hi,
                                                      // red lo/hi, green lo/hi, blue lo/hi
  input  logic                             in_tuser,  // kind
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [spr_pkg::OUT_TDATA_W-1:0]  out_tdata, // action, mode, available, clear,
                                                      // red, green, blue values
  input  logic                             cfg_wr_en,
  input  logic [spr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import spr_pkg::*;

  in_item_t  item;
  out_item_t res;
  logic      item_valid;
  logic      space;
  logic      advance;

  assign advance = item_valid && space;

  spr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  spr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step_en   (advance),
    .item      (item),
    .res       (res)
  );

  spr_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .res        (res),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- tb/spr_checker.sv -----
// ----------------------------------------------------------------------------
// spr_checker
// Watches the configuration port and both stream channels of the sensor
// supervisor. A predictor mirrors the mode, error count, poll timing and
// stored colour reading. It computes the expected result of each input
// transfer, and each result transfer is compared with the oldest one.
// ----------------------------------------------------------------------------
module spr_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [spr_pkg::IN_TDATA_W-1:0]   in_tdata,  // now_ms, outcome, clear lo/hi,
                                                      // red lo/hi, green lo/hi, blue lo/hi
  input  logic                             in_tuser,  // kind
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [spr_pkg::OUT_TDATA_W-1:0]  out_tdata, // action, mode, available, clear,
                                                      // red, green, blue values
  input  logic                             cfg_wr_en,
  input  logic [spr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output int                               fail_count,
  output int                               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import spr_pkg::*;

  // Mirrored control registers.
  logic [15:0] poll_gap_ms;
  logic [31:0] degr_wait_ms;
  logic [7:0]  err_limit;

  // Mirrored supervisor state.
  mode_t       sv_mode;
  logic [7:0]  read_errs;
  logic [31:0] last_poll_ms;
  logic [31:0] degr_mark_ms;
  logic        busy;
  act_t        issued;
  logic        have_reading;
  logic [15:0] reading [4];

  out_item_t   expected_q [$];
  int          n_results;

  initial fail_count = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    fail_count++;
    if (fail_count <= 40)
      $display("%0t: result %0d: %s is %0h, expected %0h", $realtime, n_results, what, got,
               want);
  endtask

  task automatic supervise(input logic kind, input logic [31:0] now, input logic [1:0] outc,
                           input logic [63:0] rd, output out_item_t res);
    act_t        act;
    logic [31:0] since;
    act = ACT_NONE;
    if (kind == KIND_POLL) begin
      since = now - last_poll_ms;
      // A poll during an open request is dropped without recording its time.
      if (!busy && since >= {16'd0, poll_gap_ms}) begin
        last_poll_ms = now;
        case (sv_mode)
          MODE_INIT, MODE_RETRY: act = ACT_INIT;
          MODE_RUN:              act = ACT_READ;
          MODE_BUSRST:           act = ACT_BUS;
          MODE_SOFTRST:          act = ACT_SOFT;
          default: begin
            have_reading = 1'b0;
            since = now - degr_mark_ms;
            if (since >= degr_wait_ms) begin
              degr_mark_ms = now;
              sv_mode = MODE_RETRY;
            end
          end
        endcase
        if (act != ACT_NONE) begin
          busy = 1'b1;
          issued = act;
        end
      end
    end else if (busy) begin
      busy = 1'b0;
      if (issued == ACT_READ) begin
        if (outc == OUTC_OK) begin
          reading[0] = rd[15:0];
          reading[1] = rd[31:16];
          reading[2] = rd[47:32];
          reading[3] = rd[63:48];
          have_reading = 1'b1;
          read_errs = '0;
        end else if (outc != OUTC_NOT_READY) begin
          if (read_errs != ERR_COUNT_MAX)
            read_errs = read_errs + 8'd1;
          have_reading = 1'b0;
          if (read_errs >= err_limit)
            sv_mode = MODE_RETRY;
        end
      end else if (outc == OUTC_OK) begin
        sv_mode = MODE_RUN;
        read_errs = '0;
      end else if (issued == ACT_INIT) begin
        // Any outcome other than success fails an init-type request.
        if (sv_mode == MODE_INIT)
          sv_mode = MODE_RETRY;
        else
          sv_mode = MODE_BUSRST;
      end else if (issued == ACT_BUS) begin
        sv_mode = MODE_SOFTRST;
      end else begin
        sv_mode = MODE_DEGR;
      end
      issued = ACT_NONE;
    end
    res.action      = act;
    res.mode        = sv_mode;
    res.available   = have_reading;
    res.clear_value = reading[0];
    res.red_value   = reading[1];
    res.green_value = reading[2];
    res.blue_value  = reading[3];
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t fresh;
    if (!rst_n) begin
      poll_gap_ms  = POLL_INTERVAL_RST;
      degr_wait_ms = DEGR_RETRY_RST;
      err_limit    = ERROR_LIMIT_RST;
      sv_mode      = MODE_INIT;
      read_errs    = '0;
      last_poll_ms = '0;
      degr_mark_ms = '0;
      busy         = 1'b0;
      issued       = ACT_NONE;
      have_reading = 1'b0;
      for (int i = 0; i < 4; i++)
        reading[i] = '0;
      expected_q.delete();
      n_results   = 0;
      outstanding = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_POLL_INTERVAL: poll_gap_ms  = cfg_wdata[15:0];
          CFG_DEGR_RETRY:    degr_wait_ms = cfg_wdata;
          CFG_ERROR_LIMIT:   err_limit    = cfg_wdata[7:0];
          default: ;
        endcase
      end
      // A result never leaves in the cycle of its own input transfer, so the
      // result side is handled first.
      if (out_tvalid === 1'b1 && out_tready) begin
        if (expected_q.size() == 0) begin
          report("unexpected result, action", 32'(out_tdata[2:0]), '0);
        end else begin
          want = expected_q.pop_front();
          if (out_tdata[2:0] !== want.action)
            report("action", 32'(out_tdata[2:0]), 32'(want.action));
          if (out_tdata[5:3] !== want.mode)
            report("mode", 32'(out_tdata[5:3]), 32'(want.mode));
          if (out_tdata[6] !== want.available)
            report("available", 32'(out_tdata[6]), 32'(want.available));
          if (out_tdata[22:7] !== want.clear_value)
            report("clear", 32'(out_tdata[22:7]), 32'(want.clear_value));
          if (out_tdata[38:23] !== want.red_value)
            report("red", 32'(out_tdata[38:23]), 32'(want.red_value));
          if (out_tdata[54:39] !== want.green_value)
            report("green", 32'(out_tdata[54:39]), 32'(want.green_value));
          if (out_tdata[70:55] !== want.blue_value)
            report("blue", 32'(out_tdata[70:55]), 32'(want.blue_value));
        end
        n_results++;
      end
      if (in_tvalid && in_tready === 1'b1) begin
        supervise(in_tuser, in_tdata[31:0], in_tdata[33:32], in_tdata[97:34], fresh);
        expected_q.push_back(fresh);
      end
      outstanding = expected_q.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the sensor poll recovery supervisor. A short
// directed walk through every mode and escalation step is followed by
// random poll and response sequences under several register settings,
// with bursty input, a stalling result sink and one long sink hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spr_pkg::*;

  // Outcome codes that the package leaves unnamed.
  localparam logic [1:0] OUTC_FAIL    = 2'd2;
  localparam logic [1:0] OUTC_GARBLED = 2'd3;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // now_ms, outcome, clear lo/hi, red lo/hi,
                                      // green lo/hi, blue lo/hi
  logic                   in_tuser;   // kind
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // action, mode, available, clear, red,
                                      // green, blue values
  logic                   cfg_wr_en;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  int          fail_count;
  int          outstanding;
  int          sent;
  int          burst_left;
  int          fail_pct;
  bit          hold_req;
  logic [31:0] sim_ms;
  logic [31:0] cur_ivl;

  sensor_poll_recovery_fsm DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  spr_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  // Result sink: switches between stall patterns, and honors a long hold-off
  // request counted here.
  initial begin : sink
    int hold_left;
    int cyc;
    int style;
    hold_left  = 0;
    cyc        = 0;
    style      = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 150 == 0)
        style = $urandom_range(0, 3);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (style)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ((cyc % 7) < 4);
        endcase
      end
    end
  end

  function automatic logic [63:0] random_bytes();
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // One input transfer, preceded now and then by an idle gap between bursts.
  task automatic send_item(input logic kind, input logic [31:0] now, input logic [1:0] outc,
                           input logic [63:0] rd);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {6'd0, rd, outc, now};
    do @(posedge clk); while (in_tready !== 1'b1);
    sent++;
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // A poll a little after the interval (sometimes too early), then usually a
  // response; a missing or doubled response gives the broken sequences.
  task automatic poll_then_answer();
    logic [31:0] step;
    logic [1:0]  outc;
    int          r;
    if ($urandom_range(0, 99) < 12)
      step = $urandom_range(0, cur_ivl);
    else
      step = cur_ivl + $urandom_range(0, cur_ivl / 4 + 3);
    sim_ms = sim_ms + step;
    send_item(KIND_POLL, sim_ms, 2'($urandom_range(0, 3)), random_bytes());
    if ($urandom_range(0, 99) < fail_pct)
      outc = 2'($urandom_range(1, 3));
    else
      outc = OUTC_OK;
    r = $urandom_range(0, 19);
    if (r != 0)
      send_item(KIND_RESP, $urandom, outc, random_bytes());
    if (r == 1)
      send_item(KIND_RESP, $urandom, outc, random_bytes());
  endtask

  task automatic run_phase(input logic [15:0] ivl, input logic [31:0] degr,
                           input logic [7:0] lim, input int n, input bit with_hold);
    int target;
    int next_mix;
    bit held;
    go_quiet();
    wait_drained();
    write_reg(CFG_POLL_INTERVAL, 32'(ivl));
    write_reg(CFG_DEGR_RETRY, degr);
    write_reg(CFG_ERROR_LIMIT, 32'(lim));
    cur_ivl  = 32'(ivl);
    target   = sent + n;
    next_mix = sent;
    held     = 1'b0;
    while (sent < target) begin
      // The failure rate moves between mild and harsh so that the deeper
      // recovery modes are reached as well as long healthy stretches.
      if (sent >= next_mix) begin
        case ($urandom_range(0, 2))
          0:       fail_pct = 5;
          1:       fail_pct = 35;
          default: fail_pct = 85;
        endcase
        next_mix = sent + 40;
      end
      if ($urandom_range(0, 4) == 0)
        send_item(1'($urandom_range(0, 1)), $urandom, 2'($urandom_range(0, 3)),
                  random_bytes());
      else
        poll_then_answer();
      if (with_hold && !held && sent >= target - n / 2) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = KIND_POLL;
    cfg_wr_en  = 1'b0;
    cfg_index  = CFG_POLL_INTERVAL;
    cfg_wdata  = '0;
    hold_req   = 1'b0;
    sent       = 0;
    burst_left = 0;
    fail_pct   = 35;
    sim_ms     = '0;
    cur_ivl    = 32'd100;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed walk with the register defaults.
    send_item(KIND_POLL, 32'd0, OUTC_OK, '0);        // too soon after reset time
    send_item(KIND_POLL, 32'd100, OUTC_OK, '0);      // init
    send_item(KIND_POLL, 32'd150, OUTC_OK, '0);      // dropped while waiting
    send_item(KIND_RESP, '0, OUTC_FAIL, '0);         // init fails -> retry
    send_item(KIND_RESP, '0, OUTC_OK, '1);           // nothing pending
    send_item(KIND_POLL, 32'd200, OUTC_OK, '0);
    send_item(KIND_RESP, '0, OUTC_NOT_READY, '0);    // not ready fails an init
    send_item(KIND_POLL, 32'd300, OUTC_OK, '0);
    send_item(KIND_RESP, '0, OUTC_FAIL, '0);         // bus recovery fails
    send_item(KIND_POLL, 32'd400, OUTC_OK, '0);
    send_item(KIND_RESP, '0, OUTC_GARBLED, '0);      // soft reset fails -> degraded
    send_item(KIND_POLL, 32'd500, OUTC_OK, '0);      // degraded, too early to retry
    send_item(KIND_POLL, 32'd5000, OUTC_OK, '0);     // degraded back to retry
    send_item(KIND_POLL, 32'd5100, OUTC_OK, '0);
    send_item(KIND_RESP, '0, OUTC_OK, '0);           // running
    send_item(KIND_POLL, 32'd5200, OUTC_OK, '0);
    send_item(KIND_RESP, '0, OUTC_OK, '1);           // all channels at maximum
    send_item(KIND_POLL, 32'd5300, OUTC_OK, '0);
    send_item(KIND_RESP, '0, OUTC_NOT_READY, '0);    // reading kept
    send_item(KIND_POLL, 32'd5400, OUTC_OK, '0);
    send_item(KIND_RESP, '0, OUTC_GARBLED, '0);
    send_item(KIND_POLL, 32'd5500, OUTC_OK, '0);
    send_item(KIND_RESP, '0, OUTC_FAIL, '0);
    send_item(KIND_POLL, 32'd5600, OUTC_OK, '0);
    send_item(KIND_RESP, '0, OUTC_FAIL, '0);         // third error escalates
    send_item(KIND_POLL, 32'hFFFF_FFFF, OUTC_OK, '0);
    send_item(KIND_RESP, '0, OUTC_OK, random_bytes());

    sim_ms = 32'hFFFF_FFFF;
    run_phase(16'd1,     32'd1,         8'd1,   160, 1'b0);
    run_phase(16'd20,    32'd300,       8'd2,   170, 1'b1);
    run_phase(16'd65535, 32'hFFFF_FFFF, 8'd255, 110, 1'b0);
    run_phase(16'd0,     32'd0,         8'd0,   170, 1'b0);
    sim_ms = 32'hFFFF_F000;                          // run across the time wrap
    run_phase(16'd100,   32'd5000,      8'd3,   170, 1'b0);
    run_phase(16'd37,    32'd500,       8'd4,   170, 1'b0);
    run_phase(16'd3,     32'd40,        8'd1,   170, 1'b0);

    go_quiet();
    wait_drained();
    repeat (10) @(negedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
